// ----- rtl/core/roids_pkg.sv -----
// ----------------------------------------------------------------------------
// roids_pkg
// Types and constants shared by the region-of-interest depth statistics block.
// ----------------------------------------------------------------------------
package roids_pkg;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_ROI_LEFT      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROI_TOP       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROI_RIGHT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROI_BOTTOM    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INVALID_DEPTH = 3'd4;

  // field widths
  localparam int COORD_W = 12;
  localparam int DEPTH_W = 16;
  localparam int SUM_W   = 40;
  localparam int COUNT_W = 25;
  localparam int MEAN_W  = 24;
  localparam int FRAC_W  = 8;

  // divider sequencing: one quotient bit per cycle
  localparam int DIV_STEPS = MEAN_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  // accumulator reset values
  localparam logic [DEPTH_W-1:0] DEPTH_ALL_ONES = 16'hFFFF;

  // input transaction
  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [DEPTH_W-1:0] depth_value;
    logic               frame_last;
  } pixel_t;

  // result transaction
  typedef struct packed {
    logic               stats_ok;
    logic [DEPTH_W-1:0] min_depth;
    logic [DEPTH_W-1:0] max_depth;
    logic [MEAN_W-1:0]  mean_depth_q8;
    logic [COUNT_W-1:0] valid_count;
  } stats_t;

endpackage

// ----- rtl/core/roi_depth_statistics.sv -----
// ----------------------------------------------------------------------------
// roi_depth_statistics
// Min, max, count and 16.8 mean of valid depth pixels inside a rectangle.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              payload
//  pixel     in         pixel_valid/ready      roids_pkg::pixel_t
//  stats     out        stats_valid/ready      roids_pkg::stats_t
//  cfg       in         cfg_valid/ready        cfg_index, cfg_data
//
//  An ordinary pixel is compared and accumulated in one step.
//  A frame-last pixel runs through accumulate, setup, 24 steps of the
//  shared restoring subtractor (one mean bit a cycle) and result load;
//  with nothing counted the divide steps are skipped.
//  The result sits in an output register; the next frame's pixels are taken
//  while it waits, only a second frame end stalls until it is drained.
//  rst is synchronous and restores the register defaults; cfg is always ready.
//
module roi_depth_statistics #(
  parameter int MAX_DIM = 4096
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              pixel_valid,
  output logic                              pixel_ready,
  input  roids_pkg::pixel_t                 pixel,
  output logic                              stats_valid,
  input  logic                              stats_ready,
  output roids_pkg::stats_t                 stats,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [roids_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [15:0]                       cfg_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOAD = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  localparam int DW = roids_pkg::DEPTH_W;
  localparam int CW = roids_pkg::COUNT_W;
  localparam int SW = roids_pkg::SUM_W;
  localparam int MW = roids_pkg::MEAN_W;

  logic [1:0] state;

  logic signed [15:0] roi_left;
  logic signed [15:0] roi_top;
  logic signed [15:0] roi_right;
  logic signed [15:0] roi_bottom;
  logic [DW-1:0]      invalid_depth;

  logic [DW-1:0] running_min;
  logic [DW-1:0] running_max;
  logic [SW-1:0] running_sum;
  logic [CW-1:0] running_count;

  logic [CW-1:0]                    rem;
  logic [MW-1:0]                    dvd;
  logic [MW-1:0]                    quo;
  logic [roids_pkg::STEP_W-1:0]     step;

  logic        pixel_acc;
  logic signed [16:0] px;
  logic signed [16:0] py;
  logic        in_region;
  logic        qualify;
  logic [CW:0] trial;
  logic [CW:0] diff;
  logic        fits;
  logic        out_free;

  // configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      roi_left      <= 16'sd0;
      roi_top       <= 16'sd0;
      roi_right     <= 16'sd4096;
      roi_bottom    <= 16'sd4096;
      invalid_depth <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        roids_pkg::REG_ROI_LEFT:      roi_left      <= cfg_data;
        roids_pkg::REG_ROI_TOP:       roi_top       <= cfg_data;
        roids_pkg::REG_ROI_RIGHT:     roi_right     <= cfg_data;
        roids_pkg::REG_ROI_BOTTOM:    roi_bottom    <= cfg_data;
        roids_pkg::REG_INVALID_DEPTH: invalid_depth <= cfg_data;
        default: ;
      endcase
    end
  end

  // region test, coordinates widened to signed
  assign pixel_ready = (state == S_IDLE);
  assign pixel_acc   = pixel_valid && pixel_ready;
  assign px = $signed({5'b0, pixel.pixel_x});
  assign py = $signed({5'b0, pixel.pixel_y});
  assign in_region = (px >= 17'(roi_left)) && (px < 17'(roi_right)) &&
                     (py >= 17'(roi_top)) && (py < 17'(roi_bottom)) &&
                     (32'(pixel.pixel_x) < MAX_DIM) && (32'(pixel.pixel_y) < MAX_DIM);
  assign qualify = in_region && (pixel.depth_value != invalid_depth) &&
                   !running_count[CW-1];

  // shared subtractor: one restoring division step
  assign trial = {rem, dvd[MW-1]};
  assign diff  = trial - {1'b0, running_count};
  assign fits  = !diff[CW];

  assign out_free = !stats_valid || stats_ready;

  // sequencer and accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      running_min   <= roids_pkg::DEPTH_ALL_ONES;
      running_max   <= '0;
      running_sum   <= '0;
      running_count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (pixel_acc) begin
            if (qualify) begin
              if (pixel.depth_value < running_min) running_min <= pixel.depth_value;
              if (pixel.depth_value > running_max) running_max <= pixel.depth_value;
              running_sum   <= running_sum + SW'(pixel.depth_value);
              running_count <= running_count + CW'(1);
            end
            if (pixel.frame_last) state <= S_LOAD;
          end
        end
        S_LOAD: begin
          if (running_count == '0) state <= S_DONE;
          else state <= S_DIV;
        end
        S_DIV: begin
          if (step == '0) state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state         <= S_IDLE;
            running_min   <= roids_pkg::DEPTH_ALL_ONES;
            running_max   <= '0;
            running_sum   <= '0;
            running_count <= '0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // divider registers: quotient fits 24 bits since sum <= count * 65535
  always_ff @(posedge clk) begin
    if (state == S_LOAD) begin
      rem  <= CW'(running_sum[SW-1:SW-MW]);
      dvd  <= {running_sum[SW-MW-1:0], {roids_pkg::FRAC_W{1'b0}}};
      quo  <= '0;
      step <= roids_pkg::STEP_W'(roids_pkg::DIV_STEPS - 1);
    end else if (state == S_DIV) begin
      rem  <= fits ? diff[CW-1:0] : trial[CW-1:0];
      dvd  <= {dvd[MW-2:0], 1'b0};
      quo  <= {quo[MW-2:0], fits};
      step <= step - roids_pkg::STEP_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      stats_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      stats_valid <= 1'b1;
    end else if (stats_ready) begin
      stats_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      if (running_count == '0) begin
        stats <= '0;
      end else begin
        stats.stats_ok      <= 1'b1;
        stats.min_depth     <= running_min;
        stats.max_depth     <= running_max;
        stats.mean_depth_q8 <= quo;
        stats.valid_count   <= running_count;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // division only runs on a nonzero count
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> running_count != '0)
    else $error("divider running with zero count");

  // a frame end blocks input for the following cycle
  a_last_stalls: assert property (@(posedge clk) disable iff (rst)
    pixel_acc && pixel.frame_last |=> !pixel_ready)
    else $error("input accepted right after frame end");

  // empty result carries zero fields
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    stats_valid && !stats.stats_ok |->
      stats.valid_count == '0 && stats.min_depth == '0 && stats.max_depth == '0)
    else $error("empty result with nonzero fields");

  // min never exceeds max in a valid result
  a_min_max: assert property (@(posedge clk) disable iff (rst)
    stats_valid && stats.stats_ok |-> stats.min_depth <= stats.max_depth)
    else $error("result min above max");
`endif

endmodule

// ----- sim/roi_depth_statistics_tb.sv -----
// ----------------------------------------------------------------------------
// roi_depth_statistics_tb
// Streams depth pixels through the region statistics block under several
// region settings and handshake pacings. A local model of the min, max,
// count and 16.8 mean accumulators predicts each frame result, and every
// stats transaction is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module roi_depth_statistics_tb;
  import roids_pkg::*;

  localparam int MAX_DIM = 4096;
  localparam int COORD_MAX = MAX_DIM - 1;
  localparam logic [COUNT_W-1:0] COUNT_CAP = 25'd16777216;
  // frame end runs the divider inside the block, keep a margin
  localparam int SETTLE_CYCLES = 40;
  localparam int CHUNK_PIXELS = 90;
  localparam int TIMEOUT_TIME = 5000000;

  logic clk = 1'b0;
  logic rst;
  logic pixel_valid;
  logic pixel_ready;
  pixel_t pixel;
  logic stats_valid;
  logic stats_ready;
  stats_t stats;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0] cfg_data;

  // local copy of the register file
  int roi_left_r;
  int roi_top_r;
  int roi_right_r;
  int roi_bottom_r;
  logic [DEPTH_W-1:0] invalid_depth_r;

  // local copy of the frame accumulators
  logic [DEPTH_W-1:0] acc_min;
  logic [DEPTH_W-1:0] acc_max;
  logic [SUM_W-1:0] acc_sum;
  logic [COUNT_W-1:0] acc_count;

  stats_t frame_stats_q[$];
  int error_count = 0;
  int items_sent = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hot_x = 0;
  int hot_y = 0;

  roi_depth_statistics #(
    .MAX_DIM(MAX_DIM)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .pixel_valid(pixel_valid),
    .pixel_ready(pixel_ready),
    .pixel(pixel),
    .stats_valid(stats_valid),
    .stats_ready(stats_ready),
    .stats(stats),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // random back-pressure on the stats channel
  always @(negedge clk) begin
    stats_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  task report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  task check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    end
  endtask

  function automatic int clamp_coord(input int c);
    if (c < 0) return 0;
    if (c > COORD_MAX) return COORD_MAX;
    return c;
  endfunction

  function automatic pixel_t make_pixel(input int x, input int y,
                                        input logic [DEPTH_W-1:0] d, input logic last);
    pixel_t p;
    p.pixel_x = COORD_W'(clamp_coord(x));
    p.pixel_y = COORD_W'(clamp_coord(y));
    p.depth_value = d;
    p.frame_last = last;
    return p;
  endfunction

  // depth mix biased toward the invalid code and the range ends
  function automatic logic [DEPTH_W-1:0] pick_depth();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return invalid_depth_r;
    if (r < 20) return '0;
    if (r < 25) return DEPTH_ALL_ONES;
    if (r < 30) return invalid_depth_r + DEPTH_W'($urandom_range(0, 2)) - 1'b1;
    return DEPTH_W'($urandom);
  endfunction

  function automatic int near_hot(input int c);
    return clamp_coord(c - 12 + $urandom_range(0, 24));
  endfunction

  task clear_accumulators();
    acc_min = DEPTH_ALL_ONES;
    acc_max = '0;
    acc_sum = '0;
    acc_count = '0;
  endtask

  // update the accumulators with one pixel, queue a result on frame end
  task fold_pixel_into_stats(input pixel_t p);
    int x;
    int y;
    logic in_region;
    logic [63:0] scaled;
    logic [63:0] quotient;
    stats_t s;
    x = int'(p.pixel_x);
    y = int'(p.pixel_y);
    in_region = x >= roi_left_r && x < roi_right_r && y >= roi_top_r && y < roi_bottom_r &&
                x < MAX_DIM && y < MAX_DIM;
    if (in_region && p.depth_value != invalid_depth_r && acc_count < COUNT_CAP) begin
      if (p.depth_value < acc_min) acc_min = p.depth_value;
      if (p.depth_value > acc_max) acc_max = p.depth_value;
      acc_sum = acc_sum + p.depth_value;
      acc_count = acc_count + 1'b1;
    end
    if (p.frame_last) begin
      s = '0;
      if (acc_count != 0) begin
        scaled = {24'b0, acc_sum} << FRAC_W;
        quotient = scaled / {39'b0, acc_count};
        s.stats_ok = 1'b1;
        s.min_depth = acc_min;
        s.max_depth = acc_max;
        s.mean_depth_q8 = quotient[MEAN_W-1:0];
        s.valid_count = acc_count;
      end
      frame_stats_q.push_back(s);
      clear_accumulators();
    end
  endtask

  // one pixel transaction, with random idle cycles ahead of it
  task send_pixel(input pixel_t p);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      pixel_valid <= 1'b0;
      @(negedge clk);
    end
    pixel_valid <= 1'b1;
    pixel <= p;
    do @(posedge clk); while (pixel_ready !== 1'b1);
    fold_pixel_into_stats(p);
    items_sent++;
  endtask

  // stop sending and let every pending frame result drain
  task settle_block();
    @(negedge clk);
    pixel_valid <= 1'b0;
    while (frame_stats_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one register transaction, only while the block is idle
  task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      REG_ROI_LEFT:      roi_left_r = $signed(data);
      REG_ROI_TOP:       roi_top_r = $signed(data);
      REG_ROI_RIGHT:     roi_right_r = $signed(data);
      REG_ROI_BOTTOM:    roi_bottom_r = $signed(data);
      REG_INVALID_DEPTH: invalid_depth_r = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // check each stats transaction against the oldest prediction
  always @(posedge clk) begin
    stats_t want;
    if (!rst && stats_valid === 1'b1 && stats_ready === 1'b1) begin
      if (frame_stats_q.size() == 0) begin
        report_mismatch($sformatf("unexpected stats transaction 0x%0h", stats));
      end else begin
        want = frame_stats_q.pop_front();
        check_field("stats_ok", stats.stats_ok, want.stats_ok);
        check_field("min_depth", stats.min_depth, want.min_depth);
        check_field("max_depth", stats.max_depth, want.max_depth);
        check_field("mean_depth_q8", stats.mean_depth_q8, want.mean_depth_q8);
        check_field("valid_count", stats.valid_count, want.valid_count);
      end
    end
  end

  // full-image default region, invalid code excluded, empty frame
  task test_reset_defaults();
    send_pixel(make_pixel(0, 0, 16'd1000, 1'b0));
    send_pixel(make_pixel(COORD_MAX, COORD_MAX, DEPTH_ALL_ONES, 1'b0));
    send_pixel(make_pixel(17, 3, 16'd0, 1'b0));
    send_pixel(make_pixel(COORD_MAX, 0, 16'd1, 1'b1));
    send_pixel(make_pixel(5, 5, 16'd0, 1'b1));
  endtask

  // widest region, inverted and zero-width regions, exact borders
  task test_region_edges();
    settle_block();
    write_reg(REG_ROI_LEFT, 16'h8000);
    write_reg(REG_ROI_TOP, 16'h8000);
    write_reg(REG_ROI_RIGHT, 16'h7FFF);
    write_reg(REG_ROI_BOTTOM, 16'h7FFF);
    write_reg(REG_INVALID_DEPTH, 16'hFFFF);
    send_pixel(make_pixel(0, COORD_MAX, 16'd0, 1'b0));
    send_pixel(make_pixel(COORD_MAX, 0, DEPTH_ALL_ONES, 1'b0));
    send_pixel(make_pixel(2048, 2048, 16'd12345, 1'b1));

    // inverted rectangle
    settle_block();
    write_reg(REG_ROI_LEFT, 16'd100);
    write_reg(REG_ROI_TOP, 16'd0);
    write_reg(REG_ROI_RIGHT, 16'd50);
    write_reg(REG_ROI_BOTTOM, 16'd4096);
    write_reg(REG_INVALID_DEPTH, 16'd0);
    send_pixel(make_pixel(75, 10, 16'd500, 1'b0));
    send_pixel(make_pixel(10, 10, 16'd500, 1'b1));

    // zero-width rectangle
    settle_block();
    write_reg(REG_ROI_LEFT, 16'd200);
    write_reg(REG_ROI_RIGHT, 16'd200);
    send_pixel(make_pixel(200, 5, 16'd9, 1'b1));

    // 2x2 window, pixels on and just off each border
    settle_block();
    write_reg(REG_ROI_LEFT, 16'd10);
    write_reg(REG_ROI_TOP, 16'd20);
    write_reg(REG_ROI_RIGHT, 16'd12);
    write_reg(REG_ROI_BOTTOM, 16'd22);
    write_reg(REG_INVALID_DEPTH, 16'd7);
    send_pixel(make_pixel(9, 20, 16'd1, 1'b0));
    send_pixel(make_pixel(10, 20, 16'd40000, 1'b0));
    send_pixel(make_pixel(11, 21, 16'd3, 1'b0));
    send_pixel(make_pixel(12, 21, 16'd2, 1'b0));
    send_pixel(make_pixel(10, 19, 16'd2, 1'b0));
    send_pixel(make_pixel(10, 22, 16'd2, 1'b0));
    send_pixel(make_pixel(11, 20, 16'd7, 1'b0));
    send_pixel(make_pixel(11, 20, 16'd5, 1'b1));
  endtask

  // writes to unused indexes, and a register change inside a frame
  task test_unused_index_and_midframe();
    int i;
    settle_block();
    for (i = int'(REG_INVALID_DEPTH) + 1; i < (1 << CFG_IDX_W); i++) begin
      write_reg(CFG_IDX_W'(i), 16'hFFFF);
    end
    send_pixel(make_pixel(10, 20, 16'd100, 1'b1));
    send_pixel(make_pixel(11, 21, 16'd200, 1'b0));
    settle_block();
    write_reg(REG_INVALID_DEPTH, 16'd200);
    send_pixel(make_pixel(10, 21, 16'd200, 1'b0));
    send_pixel(make_pixel(10, 20, 16'd50, 1'b1));
  endtask

  // new random region around a hot spot, sometimes inverted or wild
  task randomize_region();
    int l;
    int r;
    int t;
    int b;
    int tmp;
    hot_x = $urandom_range(0, COORD_MAX);
    hot_y = $urandom_range(0, COORD_MAX);
    l = hot_x - $urandom_range(0, 8);
    r = hot_x + $urandom_range(0, 8);
    t = hot_y - $urandom_range(0, 8);
    b = hot_y + $urandom_range(0, 8);
    if ($urandom_range(0, 9) == 0) begin
      tmp = l;
      l = r;
      r = tmp;
    end
    write_reg(REG_ROI_LEFT, ($urandom_range(0, 99) < 12) ? 16'($urandom) : 16'(l));
    write_reg(REG_ROI_TOP, ($urandom_range(0, 99) < 12) ? 16'($urandom) : 16'(t));
    write_reg(REG_ROI_RIGHT, ($urandom_range(0, 99) < 12) ? 16'($urandom) : 16'(r));
    write_reg(REG_ROI_BOTTOM, ($urandom_range(0, 99) < 12) ? 16'($urandom) : 16'(b));
    write_reg(REG_INVALID_DEPTH, ($urandom_range(0, 99) < 30) ? 16'd0 : 16'($urandom));
    if ($urandom_range(0, 9) == 0) begin
      write_reg(CFG_IDX_W'($urandom_range(int'(REG_INVALID_DEPTH) + 1, (1 << CFG_IDX_W) - 1)),
                16'($urandom));
    end
  endtask

  // small raster window near the region, last pixel closes the frame
  task send_raster_frame();
    int w;
    int h;
    int ox;
    int oy;
    int xx;
    int yy;
    w = $urandom_range(1, 10);
    h = $urandom_range(1, 8);
    ox = hot_x - $urandom_range(0, 8);
    oy = hot_y - $urandom_range(0, 8);
    for (yy = 0; yy < h; yy++) begin
      for (xx = 0; xx < w; xx++) begin
        send_pixel(make_pixel(ox + xx, oy + yy, pick_depth(),
                              (yy == h - 1) && (xx == w - 1)));
      end
    end
  endtask

  // scattered pixels, stray frame ends and frames left open
  task send_scattered_pixels();
    int len;
    int i;
    int x;
    int y;
    logic last;
    len = $urandom_range(1, 12);
    for (i = 0; i < len; i++) begin
      x = ($urandom_range(0, 1) == 0) ? $urandom_range(0, COORD_MAX) : near_hot(hot_x);
      y = ($urandom_range(0, 1) == 0) ? $urandom_range(0, COORD_MAX) : near_hot(hot_y);
      if (i == len - 1) last = ($urandom_range(0, 4) != 0);
      else last = ($urandom_range(0, 19) == 0);
      send_pixel(make_pixel(x, y, pick_depth(), last));
    end
  endtask

  // random frames under one pacing, region changed every chunk
  task test_random_frames(input int idle, input int stall, input int count);
    int start;
    int chunk_end;
    send_idle_pct = idle;
    stall_pct = stall;
    start = items_sent;
    while (items_sent - start < count) begin
      settle_block();
      randomize_region();
      chunk_end = items_sent + CHUNK_PIXELS;
      while (items_sent < chunk_end && items_sent - start < count) begin
        if ($urandom_range(0, 9) < 7) send_raster_frame();
        else send_scattered_pixels();
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    pixel_valid = 1'b0;
    pixel = '0;
    stats_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    roi_left_r = 0;
    roi_top_r = 0;
    roi_right_r = 4096;
    roi_bottom_r = 4096;
    invalid_depth_r = '0;
    clear_accumulators();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_region_edges();
    test_unused_index_and_midframe();
    test_random_frames(0, 0, 360);
    test_random_frames(54, 0, 360);
    test_random_frames(0, 54, 360);
    test_random_frames(8, 8, 370);

    settle_block();
    if (error_count == 0 && frame_stats_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // hard stop for a hung handshake
  initial begin
    #(TIMEOUT_TIME);
    $display("Test completed with failures");
    $finish;
  end

endmodule
